>>> rtl/mgli_pkg.sv
// Shared types, widths and codes of the masked gap linear interpolator.
package mgli_pkg;

    localparam int AW  = 6;   // bin address width at the largest row
    localparam int DW  = 7;   // index distance width
    localparam int PW  = 38;  // distance times error
    localparam int SW  = 78;  // sum of two squared products, even for the root
    localparam int RW  = SW / 2;
    localparam int QW  = 40;  // divider dividend and quotient
    localparam int KW  = 6;   // iteration counter
    localparam int MW  = 32 + 32 + 1;

    typedef enum logic [4:0] {
        S_LOAD, S_RD, S_CHK, S_SCAN_RD, S_SCAN_CHK, S_SETUP,
        S_SQ_LO, S_W_SQ_LO, S_SQ_HI, S_W_SQ_HI, S_SQRT, S_W_SQRT,
        S_DIV_V, S_W_DIV_V, S_DIV_E, S_W_DIV_E, S_OUT, S_OUT_F, S_SEND
    } t_state;

    typedef enum logic [2:0] {
        OP_NONE, OP_SETUP, OP_SQ_LO, OP_SQ_HI, OP_SQRT, OP_DIV_VAL, OP_DIV_ERR
    } t_op;

    typedef struct packed {
        logic          wr;
        logic          rd;
        logic [AW-1:0] addr;
        logic          cap_cur;
        logic          cap_lo;
        logic          cap_hi;
        t_op           op;
        logic [DW-1:0] dist_a;
        logic [DW-1:0] dist_b;
        logic [DW-1:0] dist_d;
        logic          load_out;
        logic          out_fill;
        logic [AW-1:0] out_idx;
        logic          out_last;
    } t_cmd;

    typedef struct packed {
        logic rd_valid;
        logic busy;
    } t_stat;

endpackage

>>> rtl/mgli_ctrl.sv
// Controller: row loading, neighbor scan and fill sequencing.
module mgli_ctrl #(
    parameter int MAX_BINS = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_last_bin,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output mgli_pkg::t_cmd o_cmd,
    input  mgli_pkg::t_stat i_stat
);
    import mgli_pkg::*;

    localparam int IW = $clog2(MAX_BINS);
    localparam int CW = $clog2(MAX_BINS + 1);

    t_state r_state, n_state;
    logic [CW-1:0] r_count, r_n, r_idx, r_scan, r_lo, r_hi;
    logic r_lo_ok, r_hi_ok, r_hi_none;
    logic acc_in, room, last_out;

    assign acc_in   = (r_state == S_LOAD) && i_in_valid;
    assign room     = r_count < CW'(MAX_BINS);
    assign last_out = (r_idx + CW'(1)) == r_n;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD: begin
                if (acc_in && i_last_bin) n_state = S_RD;
            end
            S_RD: n_state = S_CHK;
            S_CHK: begin
                if (i_stat.rd_valid || !r_lo_ok || r_hi_none) n_state = S_OUT;
                else if (r_hi_ok && (r_hi > r_idx)) n_state = S_SETUP;
                else n_state = S_SCAN_RD;
            end
            S_SCAN_RD: n_state = (r_scan == r_n) ? S_OUT : S_SCAN_CHK;
            S_SCAN_CHK: n_state = i_stat.rd_valid ? S_SETUP : S_SCAN_RD;
            S_SETUP:   n_state = S_SQ_LO;
            S_SQ_LO:   n_state = S_W_SQ_LO;
            S_W_SQ_LO: n_state = i_stat.busy ? S_W_SQ_LO : S_SQ_HI;
            S_SQ_HI:   n_state = S_W_SQ_HI;
            S_W_SQ_HI: n_state = i_stat.busy ? S_W_SQ_HI : S_SQRT;
            S_SQRT:    n_state = S_W_SQRT;
            S_W_SQRT:  n_state = i_stat.busy ? S_W_SQRT : S_DIV_V;
            S_DIV_V:   n_state = S_W_DIV_V;
            S_W_DIV_V: n_state = i_stat.busy ? S_W_DIV_V : S_DIV_E;
            S_DIV_E:   n_state = S_W_DIV_E;
            S_W_DIV_E: n_state = i_stat.busy ? S_W_DIV_E : S_OUT_F;
            S_OUT, S_OUT_F: n_state = S_SEND;
            S_SEND: begin
                if (i_out_ready) n_state = last_out ? S_LOAD : S_RD;
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.op       = OP_NONE;
        o_cmd.dist_a   = DW'(r_hi - r_idx);
        o_cmd.dist_b   = DW'(r_idx - r_lo);
        o_cmd.dist_d   = DW'(r_hi - r_lo);
        o_cmd.out_idx  = AW'(r_idx[IW-1:0]);
        o_cmd.out_last = last_out;
        o_cmd.addr     = AW'(r_idx[IW-1:0]);
        o_in_ready     = (r_state == S_LOAD);
        o_out_valid    = (r_state == S_SEND);
        unique case (r_state)
            S_LOAD: begin
                o_cmd.addr = AW'(r_count[IW-1:0]);
                o_cmd.wr   = acc_in && room;
            end
            S_RD: o_cmd.rd = 1'b1;
            S_CHK: begin
                o_cmd.cap_cur = 1'b1;
                o_cmd.cap_lo  = i_stat.rd_valid;
            end
            S_SCAN_RD: begin
                o_cmd.addr = AW'(r_scan[IW-1:0]);
                o_cmd.rd   = (r_scan != r_n);
            end
            S_SCAN_CHK: o_cmd.cap_hi = i_stat.rd_valid;
            S_SETUP: o_cmd.op = OP_SETUP;
            S_SQ_LO: o_cmd.op = OP_SQ_LO;
            S_SQ_HI: o_cmd.op = OP_SQ_HI;
            S_SQRT:  o_cmd.op = OP_SQRT;
            S_DIV_V: o_cmd.op = OP_DIV_VAL;
            S_DIV_E: o_cmd.op = OP_DIV_ERR;
            S_OUT:   o_cmd.load_out = 1'b1;
            S_OUT_F: begin
                o_cmd.load_out = 1'b1;
                o_cmd.out_fill = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_LOAD;
            r_count   <= '0;
            r_n       <= '0;
            r_idx     <= '0;
            r_scan    <= '0;
            r_lo      <= '0;
            r_hi      <= '0;
            r_lo_ok   <= 1'b0;
            r_hi_ok   <= 1'b0;
            r_hi_none <= 1'b0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_LOAD: begin
                    if (acc_in) begin
                        if (i_last_bin) begin
                            r_n       <= room ? r_count + CW'(1) : r_count;
                            r_count   <= '0;
                            r_idx     <= '0;
                            r_lo_ok   <= 1'b0;
                            r_hi_ok   <= 1'b0;
                            r_hi_none <= 1'b0;
                        end else if (room) begin
                            r_count <= r_count + CW'(1);
                        end
                    end
                end
                S_CHK: begin
                    if (i_stat.rd_valid) begin
                        r_lo    <= r_idx;
                        r_lo_ok <= 1'b1;
                    end
                    r_scan <= r_idx + CW'(1);
                end
                S_SCAN_RD: begin
                    if (r_scan == r_n) r_hi_none <= 1'b1;
                end
                S_SCAN_CHK: begin
                    if (i_stat.rd_valid) begin
                        r_hi    <= r_scan;
                        r_hi_ok <= 1'b1;
                    end else begin
                        r_scan <= r_scan + CW'(1);
                    end
                end
                S_SEND: begin
                    if (i_out_ready) r_idx <= r_idx + CW'(1);
                end
                default: ;
            endcase
        end
    end

    a_send_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEND) |-> (r_idx < r_n))
        else $error("emitting a bin beyond the row");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_BINS))
        else $error("load count past row size");

    a_fill_brackets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SETUP) |-> (r_lo_ok && r_hi_ok && r_lo < r_idx && r_hi > r_idx))
        else $error("fill started without neighbors on both sides");

endmodule

>>> rtl/mgli_dp.sv
// Datapath: bin memory, neighbor registers, serial square, root and divide.
module mgli_dp #(
    parameter int MAX_BINS = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  mgli_pkg::t_cmd  i_cmd,
    output mgli_pkg::t_stat o_stat,
    input  logic [31:0]     i_bin_value,
    input  logic [31:0]     i_bin_error,
    input  logic            i_bin_valid,
    output logic [5:0]      o_out_index,
    output logic [31:0]     o_out_value,
    output logic [31:0]     o_out_error,
    output logic            o_out_filled,
    output logic            o_out_last
);
    import mgli_pkg::*;

    localparam int IW = $clog2(MAX_BINS);

    logic [MW-1:0] mem [MAX_BINS];
    logic [MW-1:0] r_rdata;

    logic [31:0] r_cur_v, r_cur_e, r_lo_v, r_lo_e, r_hi_v, r_hi_e;
    logic [DW-1:0] r_d;
    logic signed [39:0] r_num;
    logic [PW-1:0] r_pa, r_pb, r_mq;
    logic [SW-1:0] r_mc, r_sum, r_sq;
    logic [RW+1:0] r_rem;
    logic [RW-1:0] r_root;
    logic [QW-1:0] r_dq;
    logic [7:0] r_drem, r_div;
    logic [31:0] r_fv;
    logic r_neg, r_busy;
    logic [KW-1:0] r_cnt;
    t_op r_mode;

    logic signed [7:0] sa, sb;
    logic signed [39:0] num_c;
    logic [38:0] pa_c, pb_c;
    logic [39:0] mag_c;
    logic [RW+1:0] rem_t, trial;
    logic [8:0] div_rs;
    logic div_ge;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) mem[i_cmd.addr[IW-1:0]] <= {i_bin_valid, i_bin_error, i_bin_value};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) r_rdata <= mem[i_cmd.addr[IW-1:0]];
    end

    assign o_stat.rd_valid = r_rdata[MW-1];
    assign o_stat.busy     = r_busy;

    always_comb begin
        sa     = $signed({1'b0, i_cmd.dist_a});
        sb     = $signed({1'b0, i_cmd.dist_b});
        num_c  = sa * $signed(r_lo_v) + sb * $signed(r_hi_v);
        pa_c   = {32'd0, i_cmd.dist_a} * {7'd0, r_lo_e};
        pb_c   = {32'd0, i_cmd.dist_b} * {7'd0, r_hi_e};
        mag_c  = r_num[39] ? 40'(-r_num) : 40'(r_num);
        rem_t  = {r_rem[RW-1:0], r_sq[SW-1 -: 2]};
        trial  = {r_root, 2'b01};
        div_rs = {r_drem, r_dq[QW-1]};
        div_ge = div_rs >= {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_cur) begin
            r_cur_v <= r_rdata[31:0];
            r_cur_e <= r_rdata[63:32];
        end
        if (i_cmd.cap_lo) begin
            r_lo_v <= r_rdata[31:0];
            r_lo_e <= r_rdata[63:32];
        end
        if (i_cmd.cap_hi) begin
            r_hi_v <= r_rdata[31:0];
            r_hi_e <= r_rdata[63:32];
        end
        case (i_cmd.op)
            OP_SETUP: begin
                r_num <= num_c;
                r_pa  <= pa_c[PW-1:0];
                r_pb  <= pb_c[PW-1:0];
                r_d   <= i_cmd.dist_d;
            end
            OP_SQ_LO: begin
                r_sum <= '0;
                r_mc  <= SW'(r_pa);
                r_mq  <= r_pa;
            end
            OP_SQ_HI: begin
                r_mc <= SW'(r_pb);
                r_mq <= r_pb;
            end
            OP_SQRT: begin
                r_sq   <= r_sum;
                r_rem  <= '0;
                r_root <= '0;
            end
            OP_DIV_VAL: begin
                r_neg  <= r_num[39];
                r_dq   <= {mag_c[QW-2:0], 1'b0} + QW'(r_d);
                r_div  <= {r_d, 1'b0};
                r_drem <= '0;
            end
            OP_DIV_ERR: begin
                // take the rounded value quotient before the divider is reused
                r_fv   <= r_neg ? 32'(-r_dq[31:0]) : r_dq[31:0];
                r_dq   <= QW'(r_root);
                r_div  <= {1'b0, r_d};
                r_drem <= '0;
            end
            default: ;
        endcase
        if (r_busy) begin
            case (r_mode)
                OP_SQ_LO, OP_SQ_HI: begin
                    if (r_mq[0]) r_sum <= r_sum + r_mc;
                    r_mc <= {r_mc[SW-2:0], 1'b0};
                    r_mq <= {1'b0, r_mq[PW-1:1]};
                end
                OP_SQRT: begin
                    r_sq <= {r_sq[SW-3:0], 2'b00};
                    if (rem_t >= trial) begin
                        r_rem  <= rem_t - trial;
                        r_root <= {r_root[RW-2:0], 1'b1};
                    end else begin
                        r_rem  <= rem_t;
                        r_root <= {r_root[RW-2:0], 1'b0};
                    end
                end
                OP_DIV_VAL, OP_DIV_ERR: begin
                    r_drem <= div_ge ? 8'(div_rs - {1'b0, r_div}) : div_rs[7:0];
                    r_dq   <= {r_dq[QW-2:0], div_ge};
                end
                default: ;
            endcase
        end
        if (i_cmd.load_out) begin
            o_out_index  <= i_cmd.out_idx;
            o_out_last   <= i_cmd.out_last;
            o_out_filled <= i_cmd.out_fill;
            if (i_cmd.out_fill) begin
                o_out_value <= r_fv;
                o_out_error <= (r_dq[QW-1:32] != '0) ? 32'hFFFF_FFFF : r_dq[31:0];
            end else begin
                o_out_value <= r_cur_v;
                o_out_error <= r_cur_e;
            end
        end
    end

    // iteration control: one start command, then a fixed number of steps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_mode <= OP_NONE;
        end else if (i_cmd.op != OP_NONE && i_cmd.op != OP_SETUP) begin
            r_busy <= 1'b1;
            r_mode <= i_cmd.op;
            case (i_cmd.op)
                OP_SQ_LO, OP_SQ_HI:     r_cnt <= KW'(PW - 1);
                OP_SQRT:                r_cnt <= KW'(RW - 1);
                default:                r_cnt <= KW'(QW - 1);
            endcase
        end else if (r_busy) begin
            if (r_cnt == '0) r_busy <= 1'b0;
            else r_cnt <= r_cnt - KW'(1);
        end
    end

endmodule

>>> rtl/masked_gap_linear_interpolator_core.sv
// Top level of the masked gap linear interpolator.
//
// Load one row of bins, one word per cycle, until a word with i_last_bin set;
// up to MAX_BINS bins are kept and later words of an overfull row are dropped,
// though a last bin still closes the row. The row is then emitted in index
// order, one word per bin, and no new input is taken until the final word
// (o_out_last) has been taken. An invalid bin with valid bins on both sides
// is replaced by the distance-weighted blend of its nearest valid neighbors
// (value rounded to nearest, ties away from zero; error is the floor of the
// root of the summed squared weighted errors over the distance, saturated);
// every other bin passes unchanged with o_out_filled low. A pass-through
// bin goes through a memory read, a check and an output load before the
// output handshake. A filled bin is computed by the serial arithmetic
// unit: a 38-step shift-add squarer run twice, a 39-step square root and
// a 40-step restoring divider run twice. Finding the right neighbor of a
// gap reads the bin memory once per skipped bin, once per gap. All fixed
// point formats pass straight through.
module masked_gap_linear_interpolator_core #(
    parameter int MAX_BINS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_bin_value,
    input  logic [31:0] i_bin_error,
    input  logic        i_bin_valid,
    input  logic        i_last_bin,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [5:0]  o_out_index,
    output logic [31:0] o_out_value,
    output logic [31:0] o_out_error,
    output logic        o_out_filled,
    output logic        o_out_last
);
    import mgli_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // sequence load, scan, fill and emit
    mgli_ctrl #(.MAX_BINS(MAX_BINS)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_last_bin  (i_last_bin),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    // hold the row and do the blend arithmetic
    mgli_dp #(.MAX_BINS(MAX_BINS)) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_bin_value  (i_bin_value),
        .i_bin_error  (i_bin_error),
        .i_bin_valid  (i_bin_valid),
        .o_out_index  (o_out_index),
        .o_out_value  (o_out_value),
        .o_out_error  (o_out_error),
        .o_out_filled (o_out_filled),
        .o_out_last   (o_out_last)
    );

endmodule

>>> dv/tb_masked_gap_linear_interpolator_core.sv
// Self-checking testbench for the masked gap linear interpolator core.
`timescale 1ns / 1ps

module tb_masked_gap_linear_interpolator_core;

    localparam int ROW_MAX    = 64;
    localparam int CYCLE_CAP  = 900000;
    localparam int HOLD_LEN   = 400;

    // Idle schemes of the random phases.
    typedef enum int {
        PH_FLOW, PH_SRC_IDLE, PH_SNK_STALL, PH_BOTH, PH_PRESSURE
    } t_phase;

    typedef struct {
        logic [5:0]  index;
        logic [31:0] value;
        logic [31:0] error;
        logic        filled;
        logic        last;
    } t_bin_result;

    typedef struct {
        logic [31:0] value;
        logic [31:0] error;
        logic        valid;
        logic        last;
        logic        typed;   // expected result written out by hand
        logic [31:0] x_value;
        logic [31:0] x_error;
        logic        x_filled;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [31:0] i_bin_value = '0;
    logic [31:0] i_bin_error = '0;
    logic        i_bin_valid = 1'b0;
    logic        i_last_bin = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [5:0]  o_out_index;
    logic [31:0] o_out_value;
    logic [31:0] o_out_error;
    logic        o_out_filled;
    logic        o_out_last;

    masked_gap_linear_interpolator_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_bin_value  (i_bin_value),
        .i_bin_error  (i_bin_error),
        .i_bin_valid  (i_bin_valid),
        .i_last_bin   (i_last_bin),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_index  (o_out_index),
        .o_out_value  (o_out_value),
        .o_out_error  (o_out_error),
        .o_out_filled (o_out_filled),
        .o_out_last   (o_out_last)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Shadow copy of the row being loaded.
    logic [31:0] row_value [ROW_MAX];
    logic [31:0] row_error [ROW_MAX];
    logic        row_valid [ROW_MAX];
    logic        row_typed [ROW_MAX];
    t_bin_result row_hand  [ROW_MAX];
    int          row_count = 0;

    t_bin_result pending_bins[$];
    t_phase      phase = PH_FLOW;
    bit          failed = 1'b0;
    int unsigned cycles = 0;

    // Distance-weighted value, rounded to nearest with ties away from zero.
    function automatic logic [31:0] blend_value(logic [31:0] v_lo, logic [31:0] v_hi,
                                                int a, int b);
        longint num, q;
        longint unsigned mag, d;
        begin
            d   = a + b;
            num = longint'(a) * longint'($signed(v_lo)) + longint'(b) * longint'($signed(v_hi));
            mag = (num < 0) ? -num : num;
            q   = (2 * mag + d) / (2 * d);
            if (num < 0)
                q = -q;
            return q[31:0];
        end
    endfunction

    // Floor of sqrt((a*e_lo)^2 + (b*e_hi)^2) / d, found bit by bit.
    function automatic logic [31:0] blend_error(logic [31:0] e_lo, logic [31:0] e_hi,
                                                int a, int b);
        logic [127:0] sum_sq, trial;
        logic [127:0] p_lo, p_hi;
        logic [31:0]  root;
        logic [31:0]  cand;
        begin
            p_lo   = 128'(e_lo) * 128'(a);
            p_hi   = 128'(e_hi) * 128'(b);
            sum_sq = p_lo * p_lo + p_hi * p_hi;
            root   = '0;
            for (int bit_i = 31; bit_i >= 0; bit_i--) begin
                cand  = root | (32'd1 << bit_i);
                trial = 128'(cand) * 128'(a + b);
                if (trial * trial <= sum_sq)
                    root = cand;
            end
            return root;
        end
    endfunction

    // Build the expected words of a closed row.
    task automatic emit_row();
        t_bin_result r;
        int lo, hi;
        begin
            for (int i = 0; i < row_count; i++) begin
                r.index  = i[5:0];
                r.value  = row_value[i];
                r.error  = row_error[i];
                r.filled = 1'b0;
                r.last   = (i == row_count - 1);
                if (!row_valid[i]) begin
                    lo = -1;
                    hi = -1;
                    for (int j = i - 1; j >= 0 && lo < 0; j--)
                        if (row_valid[j]) lo = j;
                    for (int j = i + 1; j < row_count && hi < 0; j++)
                        if (row_valid[j]) hi = j;
                    if (lo >= 0 && hi >= 0) begin
                        r.value  = blend_value(row_value[lo], row_value[hi], hi - i, i - lo);
                        r.error  = blend_error(row_error[lo], row_error[hi], hi - i, i - lo);
                        r.filled = 1'b1;
                    end
                end
                // Prefer the hand-written result on directed rows.
                if (row_typed[i]) begin
                    r.value  = row_hand[i].value;
                    r.error  = row_hand[i].error;
                    r.filled = row_hand[i].filled;
                end
                pending_bins.push_back(r);
            end
            row_count = 0;
        end
    endtask

    // Offer one word, wait for acceptance, then advance the shadow row.
    task automatic send_bin(t_stim_row s);
        int idle_pct;
        begin
            idle_pct = (phase == PH_SRC_IDLE) ? 72 : (phase == PH_BOTH) ? 34 : 0;
            while ($urandom_range(99) < idle_pct) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
            i_in_valid  <= 1'b1;
            i_bin_value <= s.value;
            i_bin_error <= s.error;
            i_bin_valid <= s.valid;
            i_last_bin  <= s.last;
            @(posedge i_clk);
            while (!o_in_ready)
                @(posedge i_clk);
            if (row_count < ROW_MAX) begin
                row_value[row_count]       = s.value;
                row_error[row_count]       = s.error;
                row_valid[row_count]       = s.valid;
                row_typed[row_count]       = s.typed;
                row_hand[row_count].value  = s.x_value;
                row_hand[row_count].error  = s.x_error;
                row_hand[row_count].filled = s.x_filled;
                row_count++;
            end
            if (s.last)
                emit_row();
        end
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom_range(3) - 2;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_error();
        case ($urandom_range(5))
            0: return 32'hFFFF_FFFF;
            1: return 32'h0;
            2: return $urandom_range(1 << 20);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_random_row(int len, int valid_pct);
        t_stim_row s;
        begin
            for (int i = 0; i < len; i++) begin
                s          = '{default: '0};
                s.value    = pick_value();
                s.error    = pick_error();
                s.valid    = ($urandom_range(99) < valid_pct);
                s.last     = (i == len - 1);
                send_bin(s);
            end
        end
    endtask

    // Check side: sample at the edge, then drive ready for the next one.
    int hold_left = 0;
    bit hold_done = 1'b0;
    always @(posedge i_clk) begin
        t_bin_result x;
        int stall_pct;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_bins.size() == 0) begin
                $display("%0t: unexpected word index %0d value %h error %h", $time,
                         o_out_index, o_out_value, o_out_error);
                failed = 1'b1;
            end else begin
                x = pending_bins.pop_front();
                if (o_out_index !== x.index) begin
                    $display("%0t: index exp %0d got %0d", $time, x.index, o_out_index);
                    failed = 1'b1;
                end
                if (o_out_value !== x.value) begin
                    $display("%0t: value[%0d] exp %h got %h", $time, x.index, x.value,
                             o_out_value);
                    failed = 1'b1;
                end
                if (o_out_error !== x.error) begin
                    $display("%0t: error[%0d] exp %h got %h", $time, x.index, x.error,
                             o_out_error);
                    failed = 1'b1;
                end
                if (o_out_filled !== x.filled) begin
                    $display("%0t: filled[%0d] exp %b got %b", $time, x.index, x.filled,
                             o_out_filled);
                    failed = 1'b1;
                end
                if (o_out_last !== x.last) begin
                    $display("%0t: last[%0d] exp %b got %b", $time, x.index, x.last,
                             o_out_last);
                    failed = 1'b1;
                end
            end
        end
        // Hold off once for a long stretch so the block backs up its input.
        if (phase == PH_PRESSURE && !hold_done && hold_left == 0) begin
            hold_left = HOLD_LEN;
            hold_done = 1'b1;
        end
        stall_pct = (phase == PH_SNK_STALL) ? 72 : (phase == PH_BOTH) ? 34 : 0;
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("masked_gap_linear_interpolator_core: mismatch");
            $finish;
        end
    end

    t_stim_row directed [20];

    initial begin
        // Single valid bin at the extremes passes through.
        directed[0]  = '{32'h7FFF_FFFF, 32'hFFFF_FFFF, 1, 1, 1, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0};
        // Gap between the most negative and most positive value: -1, half of max error.
        directed[1]  = '{32'h8000_0000, 32'h0, 1, 0, 1, 32'h8000_0000, 32'h0, 0};
        directed[2]  = '{32'h1234_5678, 32'h5, 0, 0, 1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1};
        directed[3]  = '{32'h7FFF_FFFF, 32'hFFFF_FFFF, 1, 1, 1, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0};
        // Edge gaps pass, a two-bin gap blends with unequal weights.
        directed[4]  = '{32'hDEAD_BEEF, 32'h11, 0, 0, 1, 32'hDEAD_BEEF, 32'h11, 0};
        directed[5]  = '{32'hFF9B_8000, 32'h0003_0000, 1, 0, 0, 0, 0, 0};
        directed[6]  = '{32'h0, 32'h0, 0, 0, 0, 0, 0, 0};
        directed[7]  = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0};
        directed[8]  = '{32'h0064_0000, 32'h0004_0000, 1, 0, 0, 0, 0, 0};
        directed[9]  = '{32'h5555_AAAA, 32'h9, 0, 1, 1, 32'h5555_AAAA, 32'h9, 0};
        // Tie rounds away from zero: midpoint of 0 and 1 is 1.
        directed[10] = '{32'h0, 32'h0, 1, 0, 0, 0, 0, 0};
        directed[11] = '{32'hAAAA_AAAA, 32'h7, 0, 0, 1, 32'h1, 32'h0, 1};
        directed[12] = '{32'h1, 32'h0, 1, 0, 0, 0, 0, 0};
        directed[13] = '{32'h0, 32'h0, 0, 0, 0, 0, 0, 0};
        directed[14] = '{32'hFFFF_FFFF, 32'h0, 1, 1, 0, 0, 0, 0};
        // Lone invalid bin.
        directed[15] = '{32'h8000_0000, 32'hFFFF_FFFF, 0, 1, 1, 32'h8000_0000, 32'hFFFF_FFFF, 0};
        // Invalid on both ends around one valid bin.
        directed[16] = '{32'h3, 32'h3, 0, 0, 1, 32'h3, 32'h3, 0};
        directed[17] = '{32'h8000_0000, 32'hFFFF_FFFF, 1, 0, 1, 32'h8000_0000, 32'hFFFF_FFFF, 0};
        directed[18] = '{32'h7FFF_FFFF, 32'h0, 0, 0, 1, 32'h7FFF_FFFF, 32'h0, 0};
        directed[19] = '{32'h7FFF_FFFF, 32'hFFFF_FFFF, 0, 1, 1, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0};

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[k])
            send_bin(directed[k]);

        // Overfull row: words beyond the store are dropped, the last bin still closes it.
        send_random_row(66, 30);

        for (int p = PH_FLOW; p <= PH_PRESSURE; p++) begin
            phase = t_phase'(p);
            repeat (2) send_random_row($urandom_range(1, 4), 50);
        end
        i_in_valid <= 1'b0;

        while (pending_bins.size() != 0)
            @(posedge i_clk);
        repeat (300) @(posedge i_clk);

        if (!failed && pending_bins.size() == 0)
            $display("masked_gap_linear_interpolator_core: match");
        else
            $display("masked_gap_linear_interpolator_core: mismatch");
        $finish;
    end

endmodule
